// ===== hw/rtl/cmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmsc_pkg
// Shared types, constants and small arithmetic helpers for the cross mean
// smoothing and terrain classification block.
// ----------------------------------------------------------------------------
package cmsc_pkg;

    // default map geometry
    localparam int DEF_MAP_WIDTH  = 10;
    localparam int DEF_MAP_HEIGHT = 10;

    // field widths
    localparam int HEIGHT_W = 4;
    localparam int CLASS_W  = 2;
    localparam int POS_W    = 6;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_MAX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_MAX = 1'd1;

    localparam logic [HEIGHT_W-1:0] WATER_MAX_RST = 4'd3;
    localparam logic [HEIGHT_W-1:0] PLAIN_MAX_RST = 4'd6;

    // terrain classes
    localparam logic [CLASS_W-1:0] CLASS_WATER = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_PLAIN = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_ROCK  = 2'd2;

    // taps of the cross around a center cell
    localparam logic [2:0] TAP_CENTER = 3'd0;
    localparam logic [2:0] TAP_LEFT   = 3'd1;
    localparam logic [2:0] TAP_RIGHT  = 3'd2;
    localparam logic [2:0] TAP_UP     = 3'd3;
    localparam logic [2:0] TAP_DOWN   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TAP,
        ST_DRAIN,
        ST_FINISH,
        ST_EMIT
    } cmsc_state_t;

    // what the current tap sweep evaluates
    typedef enum logic [1:0] {
        PH_SELF,    // cross mean of the emitted cell itself
        PH_RAW,     // raw value of a corner
        PH_HELP_V,  // smoothed vertical edge neighbor of a corner
        PH_HELP_H   // smoothed horizontal edge neighbor of a corner
    } cmsc_phase_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic                last;
    } cmsc_res_t;

    // floor(x / 5) for x up to 75, by reciprocal multiply
    function automatic logic [HEIGHT_W-1:0] div5(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[13:10];
    endfunction

    // floor(x / 3) for x up to 45, by reciprocal multiply
    function automatic logic [HEIGHT_W-1:0] div3(input logic [5:0] x);
        logic [11:0] p;
        p = 12'(x) * 12'd43;
        return p[10:7];
    endfunction

endpackage

// ===== hw/rtl/cross_mean_smooth_classify.sv =====
// ----------------------------------------------------------------------------
// cross_mean_smooth_classify
// Raster-order map smoothing with a five-point cross mean and terrain
// classification of each smoothed cell.
// ----------------------------------------------------------------------------
// Cells of a MAP_WIDTH x MAP_HEIGHT map arrive one per transfer on the s_
// channel in raster order. Each cell leaves on the m_ channel, in raster
// order, with its smoothed height, class and position, once every raw cell
// it depends on has arrived; m_tlast marks the final cell of the map, after
// which the next input starts a new map.
// Raw heights sit in one single-port-read memory; a sequencer reads the
// cross taps one per cycle and accumulates them. An input that releases no
// cell goes through the check step alone. Each released edge or interior
// cell runs check, five taps, drain, finish and emit; a corner sweeps
// three times first. s_tready is high only while the sequencer is idle.
// A finished cell waits in an output register; while the receiver stalls,
// the sequencer holds in its emit step. Reset clears the indices, the
// output valid and loads thresholds 3 and 6; the memory is not cleared.
// Thresholds are written through cfg_wr_en/cfg_index/cfg_wdata.
// ----------------------------------------------------------------------------
module cross_mean_smooth_classify #(
    parameter int MAP_WIDTH  = cmsc_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = cmsc_pkg::DEF_MAP_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_height[3:0], zeros
    input  logic [cmsc_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // smooth_height[3:0], terrain_class[5:4], cell_row[11:6], cell_col[17:12], zeros
    output logic [cmsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [cmsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cmsc_pkg::HEIGHT_W-1:0]       cfg_wdata
);
    import cmsc_pkg::*;

    localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAP_HEIGHT);
    localparam int CW    = $clog2(MAP_WIDTH);

    localparam logic [AW-1:0] W_A        = AW'(MAP_WIDTH);
    localparam logic [AW-1:0] LAST_A     = AW'(CELLS - 1);
    localparam logic [AW-1:0] NEED_TL    = AW'(2 * MAP_WIDTH);
    localparam logic [AW-1:0] NEED_TR    = AW'(3 * MAP_WIDTH - 1);
    localparam logic [AW-1:0] NEED_BL    = AW'((MAP_HEIGHT - 1) * MAP_WIDTH + 2);
    localparam logic [RW-1:0] ROW_LAST   = RW'(MAP_HEIGHT - 1);
    localparam logic [CW-1:0] COL_LAST   = CW'(MAP_WIDTH - 1);

    cmsc_state_t          state_reg;
    cmsc_state_t          state_next;
    cmsc_phase_t          phase_reg;
    cmsc_phase_t          phase_next;
    logic [2:0]           tap_reg;
    logic [2:0]           tap_next;
    logic                 pend_reg;
    logic [6:0]           acc_reg;
    logic [6:0]           acc_next;
    logic [5:0]           total_reg;
    logic [5:0]           total_next;
    logic [AW-1:0]        in_idx_reg;
    logic [AW-1:0]        cur_reg;
    logic [AW-1:0]        emit_idx_reg;
    logic [RW-1:0]        emit_row_reg;
    logic [CW-1:0]        emit_col_reg;
    logic [HEIGHT_W-1:0]  water_max_reg;
    logic [HEIGHT_W-1:0]  plain_max_reg;

    logic [HEIGHT_W-1:0]  cell_mem [CELLS];
    logic [HEIGHT_W-1:0]  rd_data_reg;

    logic                 in_xfer;
    logic                 mem_we;
    logic                 rd_en;
    logic                 res_load;
    logic                 out_free;

    logic                 top;
    logic                 bot;
    logic                 lft;
    logic                 rgt;
    logic                 corner;
    logic                 emit_last;
    logic [AW-1:0]        need_idx;
    logic                 need_ok;

    logic [RW-1:0]        ev_row;
    logic [CW-1:0]        ev_col;
    logic [AW-1:0]        ev_base;
    logic                 has_l;
    logic                 has_r;
    logic                 has_u;
    logic                 has_d;
    logic                 tap_exists;
    logic [AW-1:0]        tap_addr;
    logic [HEIGHT_W-1:0]  eval_val;
    cmsc_res_t            res;

    // position of the cell to emit
    assign top       = (emit_row_reg == '0);
    assign bot       = (emit_row_reg == ROW_LAST);
    assign lft       = (emit_col_reg == '0);
    assign rgt       = (emit_col_reg == COL_LAST);
    assign corner    = (top || bot) && (lft || rgt);
    assign emit_last = (emit_idx_reg == LAST_A);

    // highest raster index the emitted cell depends on
    always_comb begin
        if (top && lft) begin
            need_idx = NEED_TL;
        end else if (top && rgt) begin
            need_idx = NEED_TR;
        end else if (bot && lft) begin
            need_idx = NEED_BL;
        end else if (bot && rgt) begin
            need_idx = LAST_A;
        end else if (bot) begin
            need_idx = emit_idx_reg + AW'(1);
        end else begin
            need_idx = emit_idx_reg + W_A;
        end
    end

    assign need_ok = (need_idx <= cur_reg);

    // center of the cross being swept
    always_comb begin
        ev_row  = emit_row_reg;
        ev_col  = emit_col_reg;
        ev_base = emit_idx_reg;
        case (phase_reg)
            PH_HELP_V: begin
                ev_row  = top ? RW'(1) : emit_row_reg - RW'(1);
                ev_base = top ? emit_idx_reg + W_A : emit_idx_reg - W_A;
            end
            PH_HELP_H: begin
                ev_col  = lft ? CW'(1) : emit_col_reg - CW'(1);
                ev_base = lft ? emit_idx_reg + AW'(1) : emit_idx_reg - AW'(1);
            end
            default: begin
                ev_row  = emit_row_reg;
                ev_col  = emit_col_reg;
                ev_base = emit_idx_reg;
            end
        endcase
    end

    // a corner's own raw value is read alone
    assign has_l = (ev_col != '0) && (phase_reg != PH_RAW);
    assign has_r = (ev_col != COL_LAST) && (phase_reg != PH_RAW);
    assign has_u = (ev_row != '0) && (phase_reg != PH_RAW);
    assign has_d = (ev_row != ROW_LAST) && (phase_reg != PH_RAW);

    always_comb begin
        case (tap_reg)
            TAP_CENTER: begin
                tap_exists = 1'b1;
                tap_addr   = ev_base;
            end
            TAP_LEFT: begin
                tap_exists = has_l;
                tap_addr   = ev_base - AW'(1);
            end
            TAP_RIGHT: begin
                tap_exists = has_r;
                tap_addr   = ev_base + AW'(1);
            end
            TAP_UP: begin
                tap_exists = has_u;
                tap_addr   = ev_base - W_A;
            end
            TAP_DOWN: begin
                tap_exists = has_d;
                tap_addr   = ev_base + W_A;
            end
            default: begin
                tap_exists = 1'b0;
                tap_addr   = ev_base;
            end
        endcase
    end

    // mean of the finished sweep: raw, sum of four or sum of five
    always_comb begin
        if (phase_reg == PH_RAW) begin
            eval_val = acc_reg[3:0];
        end else if (has_l && has_r && has_u && has_d) begin
            eval_val = div5(acc_reg);
        end else begin
            eval_val = acc_reg[5:2];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = need_ok ? ST_TAP : ST_IDLE;
            end
            ST_TAP: begin
                if (tap_reg == TAP_DOWN) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (phase_reg == PH_SELF || phase_reg == PH_HELP_H) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_TAP;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = emit_last ? ST_IDLE : ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_TAP: begin
                rd_en = tap_exists;
            end
            ST_EMIT: begin
                res_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign in_xfer = s_tvalid && s_tready;
    assign mem_we  = in_xfer;

    // sweep datapath
    always_comb begin
        tap_next   = tap_reg;
        phase_next = phase_reg;
        total_next = total_reg;
        acc_next   = pend_reg ? acc_reg + 7'(rd_data_reg) : acc_reg;
        case (state_reg)
            ST_CHECK: begin
                tap_next   = TAP_CENTER;
                phase_next = corner ? PH_RAW : PH_SELF;
                total_next = '0;
                acc_next   = '0;
            end
            ST_TAP: begin
                tap_next = tap_reg + 3'd1;
            end
            ST_FINISH: begin
                tap_next   = TAP_CENTER;
                total_next = total_reg + 6'(eval_val);
                acc_next   = '0;
                if (phase_reg == PH_RAW) begin
                    phase_next = PH_HELP_V;
                end else if (phase_reg == PH_HELP_V) begin
                    phase_next = PH_HELP_H;
                end
            end
            default: begin
                tap_next = tap_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SELF;
            tap_reg   <= TAP_CENTER;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
            pend_reg  <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        total_reg <= total_next;
    end

    // raster indices
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_idx_reg   <= '0;
            cur_reg      <= '0;
            emit_idx_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
        end else begin
            if (in_xfer) begin
                cur_reg    <= in_idx_reg;
                in_idx_reg <= (in_idx_reg == LAST_A) ? '0 : in_idx_reg + AW'(1);
            end
            if (res_load) begin
                if (emit_last) begin
                    emit_idx_reg <= '0;
                    emit_row_reg <= '0;
                    emit_col_reg <= '0;
                end else begin
                    emit_idx_reg <= emit_idx_reg + AW'(1);
                    if (rgt) begin
                        emit_col_reg <= '0;
                        emit_row_reg <= emit_row_reg + RW'(1);
                    end else begin
                        emit_col_reg <= emit_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            water_max_reg <= WATER_MAX_RST;
            plain_max_reg <= PLAIN_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WATER_MAX: water_max_reg <= cfg_wdata;
                CFG_PLAIN_MAX: plain_max_reg <= cfg_wdata;
                default: begin
                    water_max_reg <= water_max_reg;
                end
            endcase
        end
    end

    // raw height store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[in_idx_reg] <= s_tdata[HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= cell_mem[tap_addr];
        end
    end

    always_comb begin
        res.height = corner ? div3(total_reg) : total_reg[3:0];
        res.row    = POS_W'(emit_row_reg);
        res.col    = POS_W'(emit_col_reg);
        res.last   = emit_last;
    end

    cmsc_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_load),
        .res       (res),
        .water_max (water_max_reg),
        .plain_max (plain_max_reg),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hw/rtl/cmsc_out_stage.sv =====
// ----------------------------------------------------------------------------
// cmsc_out_stage
// Output register of the result stream: classifies a finished cell against
// the water and plain thresholds and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module cmsc_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  cmsc_pkg::cmsc_res_t                 res,
    input  logic [cmsc_pkg::HEIGHT_W-1:0]       water_max,
    input  logic [cmsc_pkg::HEIGHT_W-1:0]       plain_max,
    output logic                                free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // smooth_height[3:0], terrain_class[5:4], cell_row[11:6], cell_col[17:12], zeros
    output logic [cmsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);
    import cmsc_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    cmsc_res_t            res_reg;
    logic [CLASS_W-1:0]   class_reg;
    logic [CLASS_W-1:0]   class_next;

    assign free = !valid_reg || m_tready;

    always_comb begin
        // water test first, so crossed thresholds never give plain
        if (res.height <= water_max) begin
            class_next = CLASS_WATER;
        end else if (res.height <= plain_max) begin
            class_next = CLASS_PLAIN;
        end else begin
            class_next = CLASS_ROCK;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg   <= res;
            class_reg <= class_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {(OUT_TDATA_W - HEIGHT_W - CLASS_W - 2 * POS_W)'(0),
                       res_reg.col, res_reg.row, class_reg, res_reg.height};

endmodule

// ===== tb/sv/cross_mean_smooth_classify_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_mean_smooth_classify_tb
// Streams raster maps of cell heights into the smoothing block with random
// gaps and back-pressure. Each smoothed cell, its class and its position are
// predicted in the bench and checked in order against the result transfers.
// ----------------------------------------------------------------------------
module cross_mean_smooth_classify_tb;
    import cmsc_pkg::*;

    localparam int MAP_W         = DEF_MAP_WIDTH;
    localparam int MAP_H         = DEF_MAP_HEIGHT;
    localparam int MAP_CELLS     = MAP_W * MAP_H;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 60;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [CLASS_W-1:0]  terrain;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic                map_end;
    } smoothed_cell_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_WATER_MAX;
    logic [HEIGHT_W-1:0]    cfg_wdata = '0;

    // bench copy of the map and the emit bookkeeping
    logic [HEIGHT_W-1:0] raw_map [MAP_CELLS];
    int                  next_in     = 0;
    int                  next_out    = 0;
    logic [HEIGHT_W-1:0] water_limit = WATER_MAX_RST;
    logic [HEIGHT_W-1:0] plain_limit = PLAIN_MAX_RST;
    smoothed_cell_t      pending_cells [$];

    int             mismatch_count = 0;
    bit             burst_mode     = 1'b0;
    int             rx_hold        = 0;
    int             rx_pick;
    smoothed_cell_t seen_cell;
    smoothed_cell_t want_cell;

    cross_mean_smooth_classify dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("[cross_mean_smooth_classify] ERROR");
        $finish;
    end

    // ---------------- prediction ----------------

    function automatic int raw_height(input int r, input int c);
        if (r < 0 || r >= MAP_H || c < 0 || c >= MAP_W) return 0;
        return int'(raw_map[r * MAP_W + c]);
    endfunction

    // mean of a non-corner cell, missing taps dropped on the border
    function automatic int cross_mean(input int r, input int c);
        int sum;
        if (c == 0)
            return (raw_height(r, 0) + raw_height(r, 1) + raw_height(r - 1, 0)
                    + raw_height(r + 1, 0)) / 4;
        if (c == MAP_W - 1)
            return (raw_height(r, c) + raw_height(r, c - 1) + raw_height(r - 1, c)
                    + raw_height(r + 1, c)) / 4;
        sum = raw_height(r, c - 1) + raw_height(r, c) + raw_height(r, c + 1);
        if (r == 0) return (sum + raw_height(1, c)) / 4;
        if (r == MAP_H - 1) return (sum + raw_height(r - 1, c)) / 4;
        return (sum + raw_height(r - 1, c) + raw_height(r + 1, c)) / 5;
    endfunction

    function automatic int smoothed_height(input int r, input int c);
        bit on_row_edge;
        bit on_col_edge;
        on_row_edge = (r == 0 || r == MAP_H - 1);
        on_col_edge = (c == 0 || c == MAP_W - 1);
        // corner: own raw value plus the smoothed edge neighbors
        if (on_row_edge && on_col_edge)
            return (raw_height(r, c) + cross_mean((r == 0) ? 1 : r - 1, c)
                    + cross_mean(r, (c == 0) ? 1 : c - 1)) / 3;
        return cross_mean(r, c);
    endfunction

    // last raster index a cell needs before it can leave
    function automatic int release_point(input int idx);
        int  r;
        int  c;
        bit  top;
        bit  bot;
        bit  lft;
        bit  rgt;
        r   = idx / MAP_W;
        c   = idx % MAP_W;
        top = (r == 0);
        bot = (r == MAP_H - 1);
        lft = (c == 0);
        rgt = (c == MAP_W - 1);
        if (top && lft) return 2 * MAP_W;
        if (top && rgt) return 3 * MAP_W - 1;
        if (bot && lft) return (MAP_H - 1) * MAP_W + 2;
        if (bot && rgt) return MAP_CELLS - 1;
        if (bot) return idx + 1;
        return idx + MAP_W;
    endfunction

    function automatic logic [CLASS_W-1:0] terrain_of(input logic [HEIGHT_W-1:0] v);
        if (v <= water_limit) return CLASS_WATER;
        if (v <= plain_limit) return CLASS_PLAIN;
        return CLASS_ROCK;
    endfunction

    task automatic release_cells(input logic [HEIGHT_W-1:0] h);
        int             cur;
        int             r;
        int             c;
        smoothed_cell_t next_cell;
        cur = next_in;
        raw_map[cur] = h;
        while (next_out < MAP_CELLS && release_point(next_out) <= cur) begin
            r                 = next_out / MAP_W;
            c                 = next_out % MAP_W;
            next_cell.height  = HEIGHT_W'(smoothed_height(r, c));
            next_cell.terrain = terrain_of(next_cell.height);
            next_cell.row     = POS_W'(r);
            next_cell.col     = POS_W'(c);
            next_cell.map_end = (next_out == MAP_CELLS - 1);
            pending_cells.push_back(next_cell);
            next_out++;
        end
        cur++;
        if (cur >= MAP_CELLS) begin
            next_in  = 0;
            next_out = 0;
        end else begin
            next_in = cur;
        end
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int p;
        if (burst_mode) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_height();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return '0;
        if (p == 1) return '1;
        if (p < 4) return HEIGHT_W'($urandom_range(0, 3));
        return HEIGHT_W'($urandom_range(0, 15));
    endfunction

    task automatic send_cell(input logic [HEIGHT_W-1:0] h);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(h);
        do @(posedge aclk); while (!s_tready);
        release_cells(h);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        // a transfer that releases nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [HEIGHT_W-1:0] water,
                                  input logic [HEIGHT_W-1:0] plain);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WATER_MAX;
        cfg_wdata <= water;
        @(posedge aclk);
        cfg_index <= CFG_PLAIN_MAX;
        cfg_wdata <= plain;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        water_limit = water;
        plain_limit = plain;
    endtask

    // ---------------- tests ----------------

    // full-scale and zero rows, then a mixed row start, default thresholds
    task automatic test_extreme_heights();
        for (int i = 0; i < MAP_W; i++) send_cell(4'd15);
        for (int i = 0; i < MAP_W; i++) send_cell(4'd0);
        send_cell(4'd15);
        send_cell(4'd0);
        send_cell(4'd7);
        send_cell(4'd8);
        send_cell(4'd15);
    endtask

    // rest of the first map under several threshold pairs, ending in the flush
    task automatic test_threshold_settings();
        logic [HEIGHT_W-1:0] water_set [5];
        logic [HEIGHT_W-1:0] plain_set [5];
        // includes a crossed pair where plain is below water
        water_set = '{4'd0, 4'd15, 4'd9, 4'd0, 4'd0};
        plain_set = '{4'd0, 4'd15, 4'd4, 4'd15, 4'd0};
        water_set[4] = HEIGHT_W'($urandom_range(0, 15));
        plain_set[4] = HEIGHT_W'($urandom_range(0, 15));
        for (int k = 0; k < 5; k++) begin
            wait_drained();
            set_thresholds(water_set[k], plain_set[k]);
            for (int i = 0; i < 15; i++) send_cell(pick_height());
        end
    endtask

    // a second map over the stale store: back-to-back run, gaps, a full drain, then more cells
    task automatic test_next_map();
        wait_drained();
        set_thresholds(HEIGHT_W'($urandom_range(0, 7)), HEIGHT_W'($urandom_range(4, 15)));
        burst_mode = 1'b1;
        for (int i = 0; i < 20; i++) send_cell(pick_height());
        burst_mode = 1'b0;
        for (int i = 0; i < 20; i++) send_cell(pick_height());
        wait_drained();
        for (int i = 0; i < 20; i++) send_cell(pick_height());
    endtask

    // ---------------- receiver and checker ----------------

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 15) begin
                m_tready <= 1'b1;
                rx_hold  = $urandom_range(30, 80);
            end else if (rx_pick < 60) begin
                m_tready <= 1'b1;
                rx_hold  = $urandom_range(0, 7);
            end else if (rx_pick < 88) begin
                m_tready <= 1'b0;
                rx_hold  = $urandom_range(0, 2);
            end else if (rx_pick < 97) begin
                m_tready <= 1'b0;
                rx_hold  = $urandom_range(3, 11);
            end else begin
                m_tready <= 1'b0;
                rx_hold  = $urandom_range(19, 59);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_cell = {m_tdata[3:0], m_tdata[5:4], m_tdata[11:6], m_tdata[17:12], m_tlast};
            if (pending_cells.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected transfer: row %0d col %0d height %0d",
                             seen_cell.row, seen_cell.col, seen_cell.height);
            end else begin
                want_cell = pending_cells.pop_front();
                if (seen_cell.height !== want_cell.height
                        || seen_cell.terrain !== want_cell.terrain
                        || seen_cell.row !== want_cell.row
                        || seen_cell.col !== want_cell.col
                        || seen_cell.map_end !== want_cell.map_end) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("cell mismatch: exp h=%0d cls=%0d r=%0d c=%0d last=%0d",
                                 want_cell.height, want_cell.terrain, want_cell.row,
                                 want_cell.col, want_cell.map_end);
                        $display("               got h=%0d cls=%0d r=%0d c=%0d last=%0d",
                                 seen_cell.height, seen_cell.terrain, seen_cell.row,
                                 seen_cell.col, seen_cell.map_end);
                    end
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_heights();
        test_threshold_settings();
        test_next_map();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_cells.size() == 0) begin
            $display("[cross_mean_smooth_classify] OK");
        end else begin
            $display("[cross_mean_smooth_classify] ERROR");
        end
        $finish;
    end

endmodule
